[rtl/core/efmt_pkg.sv]
// shared types, constants and helpers for the encoder frame multi-turn tracker
// no dependencies

package efmt_pkg;

    localparam int FRAME_W   = 16;
    localparam int POS_W     = 14;
    localparam int TURN_W    = 16;
    localparam int MTC_W     = 30;
    localparam int CPR_W     = 15;
    localparam int THR_W     = 14;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(3000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'b1;

    // opcodes
    localparam logic OP_TRACK  = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    localparam logic signed [MTC_W:0]   MTC_MAX_X = 31'sh1FFF_FFFF;
    localparam logic signed [MTC_W:0]   MTC_MIN_X = -31'sh2000_0000;

    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [TURN_W-1:0] turn_t;
    typedef logic signed [MTC_W-1:0]  mtc_t;

    // xor over every other position bit starting at bit first
    function automatic logic parity_from(input logic [FRAME_W-1:0] frame, input int first);
        logic acc;
        acc = 1'b0;
        for (int b = 0; b < POS_W; b++)
        begin
            if ((b % 2) == first)
            begin
                acc = acc ^ frame[b];
            end
        end
        return acc;
    endfunction

endpackage

[rtl/core/encoder_frame_multiturn_tracker.sv]
// encoder frame checker with parity test and multi-turn unwrap, depends on efmt_pkg
// a frame is held in the input register, decoded and unwrapped there, and its result is
// offered from the result register, which holds while the result side stalls
// throughput: one frame per cycle; the input stalls only while both stages are full and
// the result side holds back; the multiply-add and saturation set the path into the result register
// reset: asynchronous, active low; clears valids, turns and previous position, loads 4096/3000

module encoder_frame_multiturn_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [efmt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [efmt_pkg::CFG_W-1:0]          cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [efmt_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] raw_frame
    input  logic                                s_tuser,   // [0] opcode
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [efmt_pkg::OUT_DATA_W-1:0]     m_tdata,   // [29:0] multi_turn_count,
                                                           // [43:30] position,
                                                           // [59:44] turns, [63:60] zero
    output logic                                m_tuser    // [0] parity_ok
);

    import efmt_pkg::*;

    logic [CPR_W-1:0]   cpr_reg;
    logic [THR_W-1:0]   thr_reg;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [FRAME_W-1:0] in_frame_reg;

    pos_t               prev_pos_reg;
    turn_t              turn_reg;
    turn_t              turn_next;

    logic               out_valid_reg;
    mtc_t               out_mtc_reg;
    pos_t               out_pos_reg;
    turn_t              out_turn_reg;
    logic               out_ok_reg;

    logic               advance;
    pos_t               pos;
    pos_t               diff;
    logic               wrap_hit;
    logic               parity_ok;
    logic signed [2*TURN_W-1:0] product;
    logic signed [MTC_W+2:0]    mtc_wide;
    mtc_t               mtc_sat;

    // result register frees up as its transfer completes
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_COUNTS_PER_REV: cpr_reg <= cfg_wdata;
                REG_WRAP_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg    <= s_tuser;
            in_frame_reg <= s_tdata[FRAME_W-1:0];
        end
    end

    // frame decode and unwrap
    always_comb
    begin
        pos       = in_frame_reg[POS_W-1:0];
        parity_ok = (in_frame_reg[15] == ~parity_from(in_frame_reg, 1)) &&
                    (in_frame_reg[14] == ~parity_from(in_frame_reg, 0));
        diff      = (prev_pos_reg > pos) ? (prev_pos_reg - pos) : (pos - prev_pos_reg);
        wrap_hit  = (in_op_reg == OP_TRACK) && (diff >= thr_reg);
        turn_next = turn_reg;
        if (wrap_hit)
        begin
            // equal positions leave the count alone
            if (prev_pos_reg > pos)
            begin
                if (turn_reg != TURN_MAX)
                begin
                    turn_next = turn_reg + TURN_W'(1);
                end
            end
            else if (prev_pos_reg < pos)
            begin
                if (turn_reg != TURN_MIN)
                begin
                    turn_next = turn_reg - TURN_W'(1);
                end
            end
        end
    end

    // turns times counts per rev plus position, saturated to the output range
    always_comb
    begin
        product  = turn_next * $signed({1'b0, cpr_reg});
        mtc_wide = (MTC_W+3)'(product) + $signed({{(MTC_W+3-POS_W){1'b0}}, pos});
        priority if (mtc_wide > (MTC_W+3)'(MTC_MAX_X))
        begin
            mtc_sat = MTC_MAX_X[MTC_W-1:0];
        end
        else if (mtc_wide < (MTC_W+3)'(MTC_MIN_X))
        begin
            mtc_sat = MTC_MIN_X[MTC_W-1:0];
        end
        else
        begin
            mtc_sat = mtc_wide[MTC_W-1:0];
        end
    end

    // tracking state moves with the item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            turn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                prev_pos_reg <= pos;
                turn_reg     <= turn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_mtc_reg  <= mtc_sat;
            out_pos_reg  <= pos;
            out_turn_reg <= turn_next;
            out_ok_reg   <= parity_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_turn_reg, out_pos_reg, out_mtc_reg};
    assign m_tuser  = out_ok_reg;

    // input side only stalls when both stages hold an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with a free stage");

    // turn counter moves by at most one per item
    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ((turn_reg == $past(turn_reg)) ||
                          (turn_reg == $past(turn_reg) + TURN_W'(1)) ||
                          (turn_reg == $past(turn_reg) - TURN_W'(1))))
        else $error("turn counter jumped");

    // tracking state holds while no item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> ($stable(turn_reg) && $stable(prev_pos_reg)))
        else $error("tracking state changed without an item");

    // a registered result carries the turn count and position now held as state
    a_turn_match: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> (out_turn_reg == turn_reg && out_pos_reg == prev_pos_reg))
        else $error("result and tracking state disagree");

    // a resync item never changes the turn count
    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && in_op_reg == OP_RESYNC) |=> $stable(turn_reg))
        else $error("resync changed the turn count");

endmodule

[test/encoder_frame_multiturn_tracker_test.sv]
// testbench for encoder_frame_multiturn_tracker: directed and random frames checked
// against a local turn-tracking model, with stalls on both streams and turn stepping runs
// depends on efmt_pkg and the tracker rtl

module encoder_frame_multiturn_tracker_test;

    import efmt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [POS_W-1:0] ODD_BITS = 14'h2AAA;
    localparam logic [POS_W-1:0] EVEN_BITS = 14'h1555;
    localparam longint MTC_HIGH = 536870911;
    localparam longint MTC_LOW = -536870912;

    typedef struct packed {
        mtc_t  mtc;
        pos_t  pos;
        turn_t turns;
        logic  ok;
    } frame_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // [15:0] raw_frame
    logic                   s_tuser;    // [0] opcode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;    // [29:0] multi_turn_count, [43:30] position,
                                        // [59:44] turns, [63:60] zero
    logic                   m_tuser;    // [0] parity_ok

    // tracking model state and its copy of the registers
    pos_t               last_pos;
    turn_t              turn_count;
    logic [CPR_W-1:0]   cfg_cpr;
    logic [THR_W-1:0]   cfg_thr;

    frame_result_t      expected_results[$];
    int                 mismatches;
    int                 cycle_count;
    bit                 idle_on;
    bit                 stall_on;

    encoder_frame_multiturn_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [FRAME_W-1:0] make_frame(input pos_t pos, input bit good);
        logic [1:0] chk;
        chk = {~(^(pos & ODD_BITS)), ~(^(pos & EVEN_BITS))};
        if (!good)
        begin
            chk = chk ^ 2'($urandom_range(1, 3));
        end
        return {chk, pos};
    endfunction

    // advance the turn tracker by one frame and form the result it reports
    function automatic frame_result_t track_frame(input logic op, input logic [FRAME_W-1:0] frame);
        pos_t          pos;
        pos_t          jump;
        longint        total;
        frame_result_t r;
        pos = frame[POS_W-1:0];
        if (op == OP_TRACK)
        begin
            jump = (last_pos > pos) ? last_pos - pos : pos - last_pos;
            if (jump >= cfg_thr)
            begin
                if (last_pos > pos)
                begin
                    if (turn_count != TURN_MAX)
                    begin
                        turn_count = turn_count + turn_t'(1);
                    end
                end
                else if (last_pos < pos)
                begin
                    if (turn_count != TURN_MIN)
                    begin
                        turn_count = turn_count - turn_t'(1);
                    end
                end
            end
        end
        total = longint'(turn_count) * longint'(cfg_cpr) + longint'(pos);
        if (total > MTC_HIGH)
        begin
            total = MTC_HIGH;
        end
        if (total < MTC_LOW)
        begin
            total = MTC_LOW;
        end
        last_pos = pos;
        r.mtc = mtc_t'(total);
        r.pos = pos;
        r.turns = turn_count;
        r.ok = (frame[15] == ~(^(frame[POS_W-1:0] & ODD_BITS))) &&
               (frame[14] == ~(^(frame[POS_W-1:0] & EVEN_BITS)));
        return r;
    endfunction

    task automatic send_frame(input logic op, input logic [FRAME_W-1:0] frame);
        int gap_len;
        gap_len = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge clk);
        if (gap_len != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= frame;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(track_frame(op, frame));
    endtask

    // hold the input stream idle until every pending result has drained
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_COUNTS_PER_REV)
        begin
            cfg_cpr = value;
        end
        else
        begin
            cfg_thr = value[THR_W-1:0];
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        frame_result_t r;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, expected_results.size());
            $display("** encoder_frame_multiturn_tracker: FAILED **");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                r = expected_results.pop_front();
                check_field("multi_turn_count", longint'(r.mtc), longint'($signed(m_tdata[29:0])));
                check_field("position", longint'(r.pos), longint'(m_tdata[43:30]));
                check_field("turns", longint'(r.turns), longint'($signed(m_tdata[59:44])));
                check_field("pad", 0, longint'(m_tdata[63:60]));
                check_field("parity_ok", longint'(r.ok), longint'(m_tuser));
            end
        end
    end

    // result side back-pressure in random bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic test_reset_defaults();
        // reset values: 4096 counts per turn, wrap at 3000
        send_frame(OP_TRACK, make_frame(14'd0, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd16383, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd0, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd2999, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd0, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd3000, 1'b1));
        send_frame(OP_RESYNC, make_frame(14'd13000, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd13000, 1'b1));
    endtask

    task automatic test_frame_extremes();
        logic [FRAME_W-1:0] f;
        send_frame(OP_TRACK, 16'h0000);
        send_frame(OP_TRACK, 16'hFFFF);
        send_frame(OP_RESYNC, 16'h3FFF);
        send_frame(OP_RESYNC, 16'hC000);
        // one check bit wrong at a time, then both
        f = make_frame(14'h2A5C, 1'b1);
        send_frame(OP_TRACK, f ^ 16'h8000);
        send_frame(OP_TRACK, f ^ 16'h4000);
        send_frame(OP_TRACK, f ^ 16'hC000);
    endtask

    task automatic test_config_extremes();
        settle();
        write_reg(REG_WRAP_THRESHOLD, CFG_W'(0));
        send_frame(OP_TRACK, make_frame(last_pos, 1'b1));
        send_frame(OP_TRACK, make_frame(pos_t'(last_pos + 1'b1), 1'b1));
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(0));
        send_frame(OP_TRACK, make_frame(14'd9000, 1'b1));
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(32767));
        write_reg(REG_WRAP_THRESHOLD, CFG_W'(16383));
        send_frame(OP_TRACK, make_frame(14'd0, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd16383, 1'b1));
        send_frame(OP_TRACK, make_frame(14'd0, 1'b1));
    endtask

    // step the position by one count per frame, with a resync frame across the end of the range
    task automatic sweep_turns(input bit upward, input int count);
        repeat (count)
        begin
            if (upward)
            begin
                if (last_pos == '1)
                    send_frame(OP_RESYNC, make_frame(14'd0, $urandom_range(0, 1)));
                else
                    send_frame(OP_TRACK, make_frame(pos_t'(last_pos + 1'b1),
                                                    $urandom_range(0, 1)));
            end
            else
            begin
                if (last_pos == '0)
                    send_frame(OP_RESYNC, make_frame(14'h3FFF, $urandom_range(0, 1)));
                else
                    send_frame(OP_TRACK, make_frame(pos_t'(last_pos - 1'b1),
                                                    $urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_turn_steps();
        idle_on = 1'b0;
        stall_on = 1'b0;
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(32767));
        write_reg(REG_WRAP_THRESHOLD, CFG_W'(1));
        sweep_turns(1'b0, 40);
        // full 16384 counts per turn around the top and bottom positions
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(16384));
        send_frame(OP_RESYNC, make_frame(14'h3FFF, 1'b1));
        send_frame(OP_RESYNC, make_frame(14'd0, 1'b1));
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(32767));
        sweep_turns(1'b1, 80);
        settle();
        write_reg(REG_COUNTS_PER_REV, CFG_W'(16384));
        send_frame(OP_RESYNC, make_frame(14'd0, 1'b1));
        send_frame(OP_RESYNC, make_frame(14'h3FFF, 1'b1));
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] cpr, input logic [CFG_W-1:0] thr,
                                    input int count, input bit idle);
        int   cur;
        int   step;
        int   kind;
        logic op;
        settle();
        write_reg(REG_COUNTS_PER_REV, cpr);
        write_reg(REG_WRAP_THRESHOLD, thr);
        idle_on = idle;
        stall_on = idle;
        cur = last_pos;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                cur = $urandom_range(0, 16383);
            end
            else if (kind < 4)
            begin
                // jumps right around the wrap threshold
                step = int'(cfg_thr) + int'($urandom_range(0, 2)) - 1;
                cur = $urandom_range(0, 1) ? cur + step : cur - step;
            end
            else
            begin
                step = $urandom_range(0, 400);
                cur = $urandom_range(0, 1) ? cur + step : cur - step;
            end
            cur = ((cur % 16384) + 16384) % 16384;
            op = ($urandom_range(0, 7) == 0) ? OP_RESYNC : OP_TRACK;
            send_frame(op, make_frame(pos_t'(cur), $urandom_range(0, 3) != 0));
        end
    endtask

    task automatic test_random_tracking();
        run_random_phase(CFG_W'(CPR_RESET), CFG_W'(THR_RESET), 150, 1'b1);
        run_random_phase(CFG_W'(1), CFG_W'(1), 120, 1'b1);
        run_random_phase(CFG_W'(16384), CFG_W'(16383), 90, 1'b1);
        run_random_phase(CFG_W'(0), CFG_W'(0), 80, 1'b1);
        repeat (2)
        begin
            run_random_phase(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(0, 32767)),
                             70, 1'b1);
        end
        run_random_phase(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(0, 32767)),
                         125, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_TRACK;
        last_pos = '0;
        turn_count = '0;
        cfg_cpr = CPR_RESET;
        cfg_thr = THR_RESET;
        mismatches = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_frame_extremes();
        test_config_extremes();
        test_turn_steps();
        test_random_tracking();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** encoder_frame_multiturn_tracker: PASSED **");
        else
            $display("** encoder_frame_multiturn_tracker: FAILED **");
        $finish;
    end

endmodule
